[rtl/jsu_pkg.sv]
`timescale 1ns / 1ps

package jsu_pkg;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_STR  = 2'd1,
    PH_ESC  = 2'd2,
    PH_HEX  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_ERR   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NO_QUOTE = 2'd0,
    ERR_ESCAPE   = 2'd1,
    ERR_HEX      = 2'd2,
    ERR_UNTERM   = 2'd3
  } err_e;

  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChSlash     = 8'h2F;
  localparam logic [7:0] ChLowerB    = 8'h62;
  localparam logic [7:0] ChLowerF    = 8'h66;
  localparam logic [7:0] ChLowerN    = 8'h6E;
  localparam logic [7:0] ChLowerR    = 8'h72;
  localparam logic [7:0] ChLowerT    = 8'h74;
  localparam logic [7:0] ChLowerU    = 8'h75;
  localparam logic [7:0] ChNul       = 8'h00;

  localparam logic [7:0]  Utf8Lead2 = 8'hC0;
  localparam logic [7:0]  Utf8Lead3 = 8'hE0;
  localparam logic [7:0]  Utf8Cont  = 8'h80;
  localparam logic [5:0]  Utf8Mask  = 6'h3F;
  localparam logic [15:0] Utf8Two   = 16'h0080;
  localparam logic [15:0] Utf8Three = 16'h0800;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);

  // Work for the back end: up to three result bytes of one input item.
  typedef struct packed {
    kind_e      kind;
    err_e       err;
    logic [1:0] count;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } cmd_t;

  // Returns {valid, nibble}.
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b inside {[8'h30:8'h39]}) begin
      r = {1'b1, b[3:0]};
    end else if (b inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      r = {1'b1, 4'(b[2:0] + 3'd1) + 4'd8};
    end
    return r;
  endfunction

  function automatic cmd_t utf8_cmd(input logic [15:0] cp);
    cmd_t c;
    c.kind = KIND_BYTE;
    c.err  = ERR_NO_QUOTE;
    c.b0   = 8'd0;
    c.b1   = 8'd0;
    c.b2   = 8'd0;
    if (cp < Utf8Two) begin
      c.count = 2'd1;
      c.b0    = cp[7:0];
    end else if (cp < Utf8Three) begin
      c.count = 2'd2;
      c.b0    = Utf8Lead2 | {3'd0, cp[10:6]};
      c.b1    = Utf8Cont | {2'd0, cp[5:0] & Utf8Mask};
    end else begin
      c.count = 2'd3;
      c.b0    = Utf8Lead3 | {4'd0, cp[15:12]};
      c.b1    = Utf8Cont | {2'd0, cp[11:6] & Utf8Mask};
      c.b2    = Utf8Cont | {2'd0, cp[5:0] & Utf8Mask};
    end
    return c;
  endfunction

endpackage

[rtl/jsu_front.sv]
`timescale 1ns / 1ps

module jsu_front import jsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       full_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  phase_e      phase_q, phase_d;
  logic [1:0]  hex_cnt_q, hex_cnt_d;
  logic [15:0] cp_q, cp_d;
  logic        accept;
  logic [4:0]  hd;
  logic [15:0] cp_next;
  logic        has_result;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign hd         = hex_digit(in_byte_i);
  assign cp_next    = {cp_q[11:0], hd[3:0]};
  assign push_o     = accept && has_result;

  always_comb begin
    phase_d   = phase_q;
    hex_cnt_d = hex_cnt_q;
    cp_d      = cp_q;
    case (phase_q)
      PH_IDLE: begin
        if (in_byte_i == ChQuote) begin
          phase_d = PH_STR;
        end else begin
          hex_cnt_d = 2'd0;
          cp_d      = 16'd0;
        end
      end
      PH_STR: begin
        if (in_byte_i == ChNul) begin
          phase_d   = PH_IDLE;
          hex_cnt_d = 2'd0;
          cp_d      = 16'd0;
        end else if (in_byte_i == ChQuote) begin
          phase_d = PH_IDLE;
        end else if (in_byte_i == ChBackslash) begin
          phase_d = PH_ESC;
        end
      end
      PH_ESC: begin
        if (in_byte_i inside {ChQuote, ChBackslash, ChSlash, ChLowerB, ChLowerF,
                              ChLowerN, ChLowerR, ChLowerT}) begin
          phase_d = PH_STR;
        end else if (in_byte_i == ChLowerU) begin
          phase_d   = PH_HEX;
          hex_cnt_d = 2'd0;
          cp_d      = 16'd0;
        end else begin
          phase_d   = PH_IDLE;
          hex_cnt_d = 2'd0;
          cp_d      = 16'd0;
        end
      end
      PH_HEX: begin
        if (!hd[4]) begin
          phase_d   = PH_IDLE;
          hex_cnt_d = 2'd0;
          cp_d      = 16'd0;
        end else begin
          cp_d      = cp_next;
          hex_cnt_d = hex_cnt_q + 2'd1;
          if (hex_cnt_q == 2'd3) begin
            phase_d = PH_STR;
          end
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.kind  = KIND_BYTE;
    cmd_o.err   = ERR_NO_QUOTE;
    cmd_o.count = 2'd1;
    has_result  = 1'b1;
    case (phase_q)
      PH_IDLE: begin
        if (in_byte_i == ChQuote) begin
          has_result = 1'b0;
        end else begin
          cmd_o.kind = KIND_ERR;
        end
      end
      PH_STR: begin
        if (in_byte_i == ChNul) begin
          cmd_o.kind = KIND_ERR;
          cmd_o.err  = ERR_UNTERM;
        end else if (in_byte_i == ChQuote) begin
          cmd_o.kind = KIND_CLOSE;
        end else if (in_byte_i == ChBackslash) begin
          has_result = 1'b0;
        end else begin
          cmd_o.b0 = in_byte_i;
        end
      end
      PH_ESC: begin
        case (in_byte_i)
          ChQuote:     cmd_o.b0 = ChQuote;
          ChBackslash: cmd_o.b0 = ChBackslash;
          ChSlash:     cmd_o.b0 = ChSlash;
          ChLowerB:    cmd_o.b0 = 8'h08;
          ChLowerF:    cmd_o.b0 = 8'h0C;
          ChLowerN:    cmd_o.b0 = 8'h0A;
          ChLowerR:    cmd_o.b0 = 8'h0D;
          ChLowerT:    cmd_o.b0 = 8'h09;
          ChLowerU:    has_result = 1'b0;
          default: begin
            cmd_o.kind = KIND_ERR;
            cmd_o.err  = ERR_ESCAPE;
          end
        endcase
      end
      PH_HEX: begin
        if (!hd[4]) begin
          cmd_o.kind = KIND_ERR;
          cmd_o.err  = ERR_HEX;
        end else if (hex_cnt_q == 2'd3) begin
          cmd_o = utf8_cmd(cp_next);
        end else begin
          has_result = 1'b0;
        end
      end
      default: begin
        has_result = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      hex_cnt_q <= 2'd0;
      cp_q      <= 16'd0;
    end else if (accept) begin
      phase_q   <= phase_d;
      hex_cnt_q <= hex_cnt_d;
      cp_q      <= cp_d;
    end
  end

endmodule

[rtl/jsu_queue.sv]
`timescale 1ns / 1ps

module jsu_queue import jsu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  input  logic pop_i,
  output cmd_t head_o,
  output logic empty_o,
  output logic full_o
);

  cmd_t             mem_q [QDepth];
  logic [QAw-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QAw:0]     cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (QAw+1)'(QDepth));
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[rtl/jsu_back.sv]
`timescale 1ns / 1ps

module jsu_back import jsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       head_i,
  input  logic       empty_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output kind_e      out_kind_o,
  output logic [7:0] out_value_o,
  output err_e       out_err_o,
  output logic       out_last_o
);

  logic       valid_q;
  logic [1:0] idx_q, idx_d;
  logic       load;
  logic       at_end;
  logic [7:0] sel_byte;
  kind_e      kind_q;
  logic [7:0] value_q;
  err_e       err_q;
  logic       last_q;

  assign load   = !empty_i && (!valid_q || out_ready_i);
  assign at_end = (idx_q == head_i.count - 2'd1);
  assign pop_o  = load && at_end;
  assign idx_d  = at_end ? 2'd0 : idx_q + 2'd1;

  always_comb begin
    case (idx_q)
      2'd0:    sel_byte = head_i.b0;
      2'd1:    sel_byte = head_i.b1;
      default: sel_byte = head_i.b2;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= idx_d;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q  <= head_i.kind;
      value_q <= sel_byte;
      err_q   <= head_i.err;
      last_q  <= at_end;
    end
  end

  assign out_valid_o = valid_q;
  assign out_kind_o  = kind_q;
  assign out_value_o = value_q;
  assign out_err_o   = err_q;
  assign out_last_o  = last_q;

endmodule

[rtl/json_string_unescape_top.sv]
`timescale 1ns / 1ps

// Decodes one JSON string literal per run, taking one raw byte per item on the slave side.
// The front end accepts a byte every cycle while its four-entry work queue has room; the
// back end sends one result item per cycle from an output register while the sink is
// ready, so a byte that yields a three-byte UTF-8 sequence occupies the output for three
// items and the queue absorbs that burst. Results are decoded bytes, a string-closed mark
// or an error code, and tlast marks the final result caused by one input byte.
module json_string_unescape_top import jsu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // data_byte[7:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // value[7:0], error_code[9:8], zero[15:10]
  output logic [1:0]  m_axis_tuser,  // kind[1:0]
  output logic        m_axis_tlast
);

  cmd_t       push_cmd, head;
  logic       push, pop, empty, full;
  kind_e      out_kind;
  err_e       out_err;
  logic [7:0] out_value;

  jsu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  jsu_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (empty),
    .full_o     (full)
  );

  jsu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (out_kind),
    .out_value_o (out_value),
    .out_err_o   (out_err),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, out_err, out_value};
  assign m_axis_tuser = out_kind;

  a_ready_iff_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == !full)
    else $error("input ready does not follow queue room");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && full))
    else $error("push into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && empty))
    else $error("pop from an empty queue");

  a_close_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == KIND_CLOSE || m_axis_tuser == KIND_ERR))
      |-> m_axis_tlast)
    else $error("close or error result not marked last");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import jsu_pkg::*;

  localparam int CycleLimit   = 400000;
  localparam int RandomItems  = 500;
  localparam int DrainCycles  = 20;
  localparam int LongHold     = 150;
  localparam int DirectedRows = 33;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] value;
    err_e       err;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [7:0] data;
    logic       typed;
    kind_e      kind;
    logic [7:0] value;
    err_e       err;
  } stim_row_t;

  localparam logic [7:0] EscChars [8] = '{ChQuote, ChBackslash, ChSlash, ChLowerB,
                                          ChLowerF, ChLowerN, ChLowerR, ChLowerT};

  localparam stim_row_t Directed [DirectedRows] = '{
    '{8'h41,       1'b1, KIND_ERR,   8'h00, ERR_NO_QUOTE},
    '{ChNul,       1'b1, KIND_ERR,   8'h00, ERR_NO_QUOTE},
    '{ChQuote,     1'b0, KIND_BYTE,  8'h00, ERR_NO_QUOTE},
    '{8'hFF,       1'b1, KIND_BYTE,  8'hFF, ERR_NO_QUOTE},
    '{8'h01,       1'b1, KIND_BYTE,  8'h01, ERR_NO_QUOTE},
    '{ChBackslash, 1'b0, KIND_BYTE,  8'h00, ERR_NO_QUOTE},
    '{ChLowerU,    1'b0, KIND_BYTE,  8'h00, ERR_NO_QUOTE},
    '{8'h30,       1'b0, KIND_BYTE,  8'h00, ERR_NO_QUOTE},
    '{8'h30,       1'b0, KIND_BYTE,  8'h00, ERR_NO_QUOTE},
    '{8'h30,       1'b0, KIND_BYTE,  8'h00, ERR_NO_QUOTE},
    '{8'h30,       1'b1, KIND_BYTE,  8'h00, ERR_NO_QUOTE},
    '{ChBackslash, 1'b0, KIND_BYTE,  8'h00, ERR_NO_QUOTE},
    '{ChLowerU,    1'b0, KIND_BYTE,  8'h00, ERR_NO_QUOTE},
    '{8'h44,       1'b0, KIND_BYTE,  8'h00, ERR_NO_QUOTE},
    '{8'h38,       1'b0, KIND_BYTE,  8'h00, ERR_NO_QUOTE},
    '{8'h30,       1'b0, KIND_BYTE,  8'h00, ERR_NO_QUOTE},
    '{8'h30,       1'b0, KIND_BYTE,  8'h00, ERR_NO_QUOTE},
    '{ChBackslash, 1'b0, KIND_BYTE,  8'h00, ERR_NO_QUOTE},
    '{ChLowerU,    1'b0, KIND_BYTE,  8'h00, ERR_NO_QUOTE},
    '{8'h30,       1'b0, KIND_BYTE,  8'h00, ERR_NO_QUOTE},
    '{8'h37,       1'b0, KIND_BYTE,  8'h00, ERR_NO_QUOTE},
    '{8'h66,       1'b0, KIND_BYTE,  8'h00, ERR_NO_QUOTE},
    '{8'h46,       1'b0, KIND_BYTE,  8'h00, ERR_NO_QUOTE},
    '{ChQuote,     1'b1, KIND_CLOSE, 8'h00, ERR_NO_QUOTE},
    '{ChQuote,     1'b0, KIND_BYTE,  8'h00, ERR_NO_QUOTE},
    '{ChNul,       1'b1, KIND_ERR,   8'h00, ERR_UNTERM},
    '{ChQuote,     1'b0, KIND_BYTE,  8'h00, ERR_NO_QUOTE},
    '{ChBackslash, 1'b0, KIND_BYTE,  8'h00, ERR_NO_QUOTE},
    '{ChNul,       1'b1, KIND_ERR,   8'h00, ERR_ESCAPE},
    '{ChQuote,     1'b0, KIND_BYTE,  8'h00, ERR_NO_QUOTE},
    '{ChBackslash, 1'b0, KIND_BYTE,  8'h00, ERR_NO_QUOTE},
    '{ChLowerU,    1'b0, KIND_BYTE,  8'h00, ERR_NO_QUOTE},
    '{8'h67,       1'b1, KIND_ERR,   8'h00, ERR_HEX}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data = 8'h00;
  logic        m_tready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  json_string_unescape_top u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  phase_e      dec_phase = PH_IDLE;
  logic [1:0]  dec_digits = 2'd0;
  logic [15:0] dec_code = 16'd0;
  result_t     step_results [$];
  result_t     pending_results [$];

  int  fail_count = 0;
  int  cycle_count = 0;
  int  items_sent = 0;
  int  results_checked = 0;
  int  strings_sent = 0;
  int  errors_injected = 0;
  bit  send_steady = 1'b0;
  bit  recv_steady = 1'b0;
  bit  hold_off_req = 1'b0;

  function automatic logic [4:0] hex_nibble(input logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) begin
      return {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      return {1'b1, 4'(b - 8'h61 + 8'd10)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      return {1'b1, 4'(b - 8'h41 + 8'd10)};
    end
    return 5'd0;
  endfunction

  function automatic logic [8:0] simple_escape(input logic [7:0] b);
    case (b)
      ChQuote:     return {1'b1, ChQuote};
      ChBackslash: return {1'b1, ChBackslash};
      ChSlash:     return {1'b1, ChSlash};
      ChLowerB:    return {1'b1, 8'h08};
      ChLowerF:    return {1'b1, 8'h0C};
      ChLowerN:    return {1'b1, 8'h0A};
      ChLowerR:    return {1'b1, 8'h0D};
      ChLowerT:    return {1'b1, 8'h09};
      default:     return 9'd0;
    endcase
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
    if (n < 4'd10) begin
      return 8'h30 + 8'(n);
    end
    return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  task automatic push_result(input kind_e k, input logic [7:0] v, input err_e e,
                             input logic l);
    result_t r;
    r.kind  = k;
    r.value = v;
    r.err   = e;
    r.last  = l;
    step_results.insert(step_results.size(), r);
  endtask

  task automatic abort_string(input err_e e);
    dec_phase  = PH_IDLE;
    dec_digits = 2'd0;
    dec_code   = 16'd0;
    push_result(KIND_ERR, 8'h00, e, 1'b1);
  endtask

  task automatic unescape_step(input logic [7:0] b);
    logic [8:0]  esc;
    logic [4:0]  nib;
    logic [15:0] cp;
    step_results.delete();
    case (dec_phase)
      PH_IDLE: begin
        if (b == ChQuote) begin
          dec_phase = PH_STR;
        end else begin
          abort_string(ERR_NO_QUOTE);
        end
      end
      PH_STR: begin
        if (b == ChNul) begin
          abort_string(ERR_UNTERM);
        end else if (b == ChQuote) begin
          dec_phase = PH_IDLE;
          push_result(KIND_CLOSE, 8'h00, ERR_NO_QUOTE, 1'b1);
        end else if (b == ChBackslash) begin
          dec_phase = PH_ESC;
        end else begin
          push_result(KIND_BYTE, b, ERR_NO_QUOTE, 1'b1);
        end
      end
      PH_ESC: begin
        esc = simple_escape(b);
        if (b == ChLowerU) begin
          dec_phase  = PH_HEX;
          dec_digits = 2'd0;
          dec_code   = 16'd0;
        end else if (esc[8]) begin
          dec_phase = PH_STR;
          push_result(KIND_BYTE, esc[7:0], ERR_NO_QUOTE, 1'b1);
        end else begin
          abort_string(ERR_ESCAPE);
        end
      end
      default: begin
        nib = hex_nibble(b);
        if (!nib[4]) begin
          abort_string(ERR_HEX);
        end else begin
          dec_code = {dec_code[11:0], nib[3:0]};
          if (dec_digits == 2'd3) begin
            dec_phase  = PH_STR;
            dec_digits = 2'd0;
            cp = dec_code;
            if (cp < 16'h0080) begin
              push_result(KIND_BYTE, cp[7:0], ERR_NO_QUOTE, 1'b1);
            end else if (cp < 16'h0800) begin
              push_result(KIND_BYTE, {3'b110, cp[10:6]}, ERR_NO_QUOTE, 1'b0);
              push_result(KIND_BYTE, {2'b10, cp[5:0]}, ERR_NO_QUOTE, 1'b1);
            end else begin
              push_result(KIND_BYTE, {4'b1110, cp[15:12]}, ERR_NO_QUOTE, 1'b0);
              push_result(KIND_BYTE, {2'b10, cp[11:6]}, ERR_NO_QUOTE, 1'b0);
              push_result(KIND_BYTE, {2'b10, cp[5:0]}, ERR_NO_QUOTE, 1'b1);
            end
          end else begin
            dec_digits = dec_digits + 2'd1;
          end
        end
      end
    endcase
  endtask

  task automatic flag_error(input string msg);
    $display("ERROR at cycle %0d: %s", cycle_count, msg);
    fail_count++;
  endtask

  task automatic send_item(input logic [7:0] b, input logic typed, input result_t want);
    int gap;
    gap = send_steady ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    unescape_step(b);
    if (typed) begin
      pending_results.insert(pending_results.size(), want);
    end else begin
      foreach (step_results[i]) begin
        pending_results.insert(pending_results.size(), step_results[i]);
      end
    end
  endtask

  task automatic wait_for_results();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_string(output int n_items);
    logic [7:0]  seq [$];
    logic [7:0]  b;
    logic [15:0] cp;
    logic [4:0]  nib;
    result_t     none;
    int          broken;
    none = '0;
    seq.delete();
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        do b = 8'($urandom); while (b == ChQuote);
        seq.insert(seq.size(), b);
      end
      errors_injected++;
    end
    seq.insert(seq.size(), ChQuote);
    repeat ($urandom_range(0, 10)) begin
      case ($urandom_range(0, 3))
        0, 1: begin
          do b = 8'($urandom_range(1, 255)); while (b == ChQuote || b == ChBackslash);
          seq.insert(seq.size(), b);
        end
        2: begin
          seq.insert(seq.size(), ChBackslash);
          seq.insert(seq.size(), EscChars[$urandom_range(0, 7)]);
        end
        default: begin
          case ($urandom_range(0, 4))
            0: cp = 16'($urandom_range(0, 16'h007F));
            1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
            2: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
            3: cp = 16'($urandom_range(16'hD800, 16'hDFFF));
            default: begin
              case ($urandom_range(0, 5))
                0: cp = 16'h0000;
                1: cp = 16'h007F;
                2: cp = 16'h0080;
                3: cp = 16'h07FF;
                4: cp = 16'h0800;
                default: cp = 16'hFFFF;
              endcase
            end
          endcase
          seq.insert(seq.size(), ChBackslash);
          seq.insert(seq.size(), ChLowerU);
          for (int i = 3; i >= 0; i--) begin
            seq.insert(seq.size(), hex_char(cp[i*4 +: 4], bit'($urandom_range(0, 1))));
          end
        end
      endcase
    end
    broken = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
    case (broken)
      0: seq.insert(seq.size(), ChQuote);
      1: seq.insert(seq.size(), ChNul);
      2: begin
        seq.insert(seq.size(), ChBackslash);
        do b = 8'($urandom); while (simple_escape(b) != 9'd0 || b == ChLowerU);
        seq.insert(seq.size(), b);
      end
      default: begin
        seq.insert(seq.size(), ChBackslash);
        seq.insert(seq.size(), ChLowerU);
        repeat ($urandom_range(0, 3)) seq.insert(seq.size(), hex_char(4'($urandom), 1'b0));
        do begin
          b = 8'($urandom);
          nib = hex_nibble(b);
        end while (nib[4]);
        seq.insert(seq.size(), b);
      end
    endcase
    if (broken != 0) errors_injected++;
    if ($urandom_range(0, 3) == 0) send_steady = !send_steady;
    foreach (seq[i]) send_item(seq[i], 1'b0, none);
    n_items = seq.size();
    strings_sent++;
  endtask

  initial begin
    int random_sent;
    int n;
    bit held;
    bit mid_drain;
    result_t want;
    random_sent = 0;
    held = 1'b0;
    mid_drain = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < DirectedRows; i++) begin
      want.kind  = Directed[i].kind;
      want.value = Directed[i].value;
      want.err   = Directed[i].err;
      want.last  = 1'b1;
      send_item(Directed[i].data, Directed[i].typed, want);
    end
    s_valid <= 1'b0;
    wait_for_results();
    while (random_sent < RandomItems) begin
      if (!held && random_sent >= 40) begin
        held = 1'b1;
        hold_off_req = 1'b1;
        send_steady = 1'b1;
      end
      if (!mid_drain && random_sent >= RandomItems / 2) begin
        mid_drain = 1'b1;
        s_valid <= 1'b0;
        wait_for_results();
        @(posedge clk);
      end
      send_random_string(n);
      random_sent += n;
    end
    s_valid <= 1'b0;
    wait_for_results();
    repeat (DrainCycles) @(posedge clk);
    $display("Sent %0d input items in %0d strings plus the directed table; checked %0d results.",
             items_sent, strings_sent, results_checked);
    $display("Covered plain bytes, all escapes, unicode escapes of one to three bytes and %0d %s",
             errors_injected, "broken or noisy strings, with a long output stall.");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    int      gap;
    result_t got;
    result_t want;
    wait (rst_n);
    forever begin
      if ($urandom_range(0, 39) == 0) recv_steady = !recv_steady;
      gap = recv_steady ? 0 : $urandom_range(0, 17);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        gap = LongHold;
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      got.kind  = kind_e'(m_axis_tuser);
      got.value = m_axis_tdata[7:0];
      got.err   = err_e'(m_axis_tdata[9:8]);
      got.last  = m_axis_tlast;
      if (pending_results.size() == 0) begin
        flag_error($sformatf("unexpected result kind=%0d value=%h err=%0d last=%0b",
                             got.kind, got.value, got.err, got.last));
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (got.kind != want.kind || got.value != want.value || got.err != want.err ||
            got.last != want.last || m_axis_tdata[15:10] != 6'd0) begin
          flag_error($sformatf({"result kind=%0d value=%h err=%0d last=%0b pad=%h, ",
                                "expected kind=%0d value=%h err=%0d last=%0b"},
                               got.kind, got.value, got.err, got.last, m_axis_tdata[15:10],
                               want.kind, want.value, want.err, want.last));
        end
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
             pending_results.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

[filelist.f]
rtl/jsu_pkg.sv
rtl/jsu_front.sv
rtl/jsu_queue.sv
rtl/jsu_back.sv
rtl/json_string_unescape_top.sv
tb/testbench.sv
